>>> rtl/vrme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrme_pkg: shared types and constants for the voxel ray march editor
// Grid geometry, fixed-point widths, item kind codes and the cell address
// helper used by the top level.
// ----------------------------------------------------------------------------
package vrme_pkg;

  // grid geometry
  localparam int GRID_SIZE = 16;
  localparam int DEPTH     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int GB        = $clog2(GRID_SIZE);

  // world cell coordinate while marching, and local coordinate for range check
  localparam int W_W = 10;
  localparam int LW  = W_W + 1;

  // sub-cell position: remainder in units of 1/(20*2^14) of a cell
  localparam int POS_DEN      = 327680;
  localparam int ORIGIN_SCALE = 1280;
  localparam int R_W          = 19;
  localparam int SUM_W        = R_W + 2;

  // stream widths
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 32;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_BREAK = 2'd2;
  localparam logic [1:0] KIND_PLACE = 2'd3;

  // normal axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X  = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y  = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Z  = 2'd2;
  localparam logic [1:0] CFG_MAX_STEPS = 2'd3;

  localparam logic [7:0] MAX_STEPS_RESET = 8'd120;

  // per-axis stepper control
  typedef struct packed {
    logic adv;
    logic load;
  } step_ctl_t;

  // store address of a world cell and whether it lies inside the grid
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } cell_ref_t;

  // one result item, hit in the lowest bit
  typedef struct packed {
    logic              solid;
    logic              normal_negative;
    logic [1:0]        normal_axis;
    logic signed [7:0] hit_z;
    logic signed [7:0] hit_y;
    logic signed [7:0] hit_x;
    logic              hit;
  } result_t;

  function automatic cell_ref_t cell_addr(
    input logic signed [W_W-1:0] wx,
    input logic signed [W_W-1:0] wy,
    input logic signed [W_W-1:0] wz,
    input logic signed [7:0]     gx,
    input logic signed [7:0]     gy,
    input logic signed [7:0]     gz
  );
    logic signed [LW-1:0] lx;
    logic signed [LW-1:0] ly;
    logic signed [LW-1:0] lz;
    logic signed [LW-1:0] gs;
    cell_ref_t            c;
    lx = LW'(wx) - LW'(gx);
    ly = LW'(wy) - LW'(gy);
    lz = LW'(wz) - LW'(gz);
    gs = LW'(GRID_SIZE);
    c.ok = !lx[LW-1] && !ly[LW-1] && !lz[LW-1] && (lx < gs) && (ly < gs) && (lz < gs);
    c.addr = (ADDR_W'(lx[GB-1:0]) * ADDR_W'(GRID_SIZE) + ADDR_W'(ly[GB-1:0]))
             * ADDR_W'(GRID_SIZE) + ADDR_W'(lz[GB-1:0]);
    return c;
  endfunction

endpackage

>>> rtl/vrme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrme_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vrme_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/vrme_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrme_axis: one axis of the ray stepper
// Keeps the current world cell and the exact sub-cell remainder, and moves
// them by one fixed step of the ray direction per advance.
// ----------------------------------------------------------------------------
module vrme_axis (
  input  logic                          clk,
  input  vrme_pkg::step_ctl_t           ctl,
  input  logic signed [15:0]            origin,
  input  logic signed [15:0]            dir,
  output logic signed [vrme_pkg::W_W-1:0] world_cell
);

  logic signed [vrme_pkg::W_W-1:0]   w_r;
  logic [vrme_pkg::R_W-1:0]          r_r;
  logic signed [vrme_pkg::SUM_W-1:0] sum;
  logic signed [vrme_pkg::SUM_W-1:0] den;

  // remainder plus one step, step is far below one cell
  always_comb begin
    den = vrme_pkg::SUM_W'(vrme_pkg::POS_DEN);
    sum = signed'(vrme_pkg::SUM_W'(r_r)) + vrme_pkg::SUM_W'(dir);
  end

  // load from the Q8.8 origin, then carry or borrow one cell at a time
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      w_r <= vrme_pkg::W_W'(signed'(origin[15:8]));
      r_r <= vrme_pkg::R_W'(origin[7:0]) * vrme_pkg::R_W'(vrme_pkg::ORIGIN_SCALE);
    end else if (ctl.adv) begin
      if (sum >= den) begin
        r_r <= vrme_pkg::R_W'(sum - den);
        w_r <= w_r + vrme_pkg::W_W'(1);
      end else if (sum < 0) begin
        r_r <= vrme_pkg::R_W'(sum + den);
        w_r <= w_r - vrme_pkg::W_W'(1);
      end else begin
        r_r <= vrme_pkg::R_W'(sum);
      end
    end
  end

  assign world_cell = w_r;

endmodule

>>> rtl/voxel_ray_march_edit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_march_edit: voxel occupancy store with fixed-step ray picking
// Write, query, break and place items against a cubic one-bit voxel store.
// ----------------------------------------------------------------------------
// Usage:
// - in_* carries one item; in_tuser selects write, query, break or place.
// - out_* returns exactly one result item per input item, in order.
// - cfg_* writes grid origin x/y/z (index 0..2) and max steps (index 3);
//   write it only while no item is in flight. cfg_ready is always high.
// - After reset the store is swept to empty, one cell per cycle, over all
//   4096 cells (GRID_SIZE cubed); in_tready stays low until it is done.
// - A ray reads at most max_steps cells, fewer on an early hit. It reads one
//   cell per cycle through the store's single read port, which sets the rate.
// - One item is worked at a time; the next is accepted while the last
//   result waits in the output register.
// - If out_tready is low, a finished result waits in the output register;
//   a further finished item holds until that register frees.
// ----------------------------------------------------------------------------
module voxel_ray_march_edit (
  input  logic                              clk,
  input  logic                              rst_n,
  // x[7:0] y[15:8] z[23:16] value[24] origin x/y/z [40:25][56:41][72:57]
  // dir x/y/z [88:73][104:89][120:105], zero pad [127:121]
  input  logic [vrme_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind[1:0]
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // hit[0] hit_x[8:1] hit_y[16:9] hit_z[24:17] normal_axis[26:25]
  // normal_negative[27] solid[28], zero pad [31:29]
  output logic [vrme_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [7:0]                        cfg_data
);

  localparam int W_W    = vrme_pkg::W_W;
  localparam int ADDR_W = vrme_pkg::ADDR_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_QRD,
    ST_MARCH,
    ST_EDIT,
    ST_DONE
  } state_t;

  state_t                 state_r;
  logic [ADDR_W-1:0]      clr_addr_r;

  // configuration
  logic signed [7:0]      go_x_r;
  logic signed [7:0]      go_y_r;
  logic signed [7:0]      go_z_r;
  logic [7:0]             max_steps_r;

  // latched item
  logic [1:0]             kind_r;
  logic signed [7:0]      cx_r;
  logic signed [7:0]      cy_r;
  logic signed [7:0]      cz_r;
  logic                   cval_r;
  logic signed [15:0]     dx_r;
  logic signed [15:0]     dy_r;
  logic signed [15:0]     dz_r;

  // march pipeline
  logic [7:0]             issue_k_r;
  logic                   pipe_valid_r;
  logic                   pipe_ok_r;
  logic                   pipe_first_r;
  logic signed [W_W-1:0]  pw_x_r;
  logic signed [W_W-1:0]  pw_y_r;
  logic signed [W_W-1:0]  pw_z_r;

  logic                   q_ok_r;
  logic                   edit_ok_r;
  logic [ADDR_W-1:0]      edit_addr_r;
  logic                   edit_val_r;

  vrme_pkg::result_t      res_r;
  vrme_pkg::result_t      out_r;
  logic                   out_valid_r;

  logic                   in_acc;
  logic                   issue;
  logic                   hit_now;
  vrme_pkg::step_ctl_t    step_ctl;
  logic signed [W_W-1:0]  wx;
  logic signed [W_W-1:0]  wy;
  logic signed [W_W-1:0]  wz;
  vrme_pkg::cell_ref_t    cell_ref;
  vrme_pkg::cell_ref_t    march_ref;
  vrme_pkg::cell_ref_t    hit_ref;
  vrme_pkg::cell_ref_t    place_ref;
  logic [16:0]            ax;
  logic [16:0]            ay;
  logic [16:0]            az;
  logic [1:0]             n_axis;
  logic                   n_neg;
  logic signed [W_W-1:0]  off;
  logic signed [W_W-1:0]  tx;
  logic signed [W_W-1:0]  ty;
  logic signed [W_W-1:0]  tz;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [0:0]             ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [0:0]             ram_rdata;

  // handshakes
  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = vrme_pkg::OUT_DATA_W'(out_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_x_r      <= '0;
      go_y_r      <= '0;
      go_z_r      <= '0;
      max_steps_r <= vrme_pkg::MAX_STEPS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vrme_pkg::CFG_ORIGIN_X:  go_x_r      <= cfg_data;
        vrme_pkg::CFG_ORIGIN_Y:  go_y_r      <= cfg_data;
        vrme_pkg::CFG_ORIGIN_Z:  go_z_r      <= cfg_data;
        vrme_pkg::CFG_MAX_STEPS: max_steps_r <= cfg_data;
        default:                 max_steps_r <= max_steps_r;
      endcase
    end
  end

  // ray steppers, loaded on accept and advanced on each issued read
  assign issue         = (state_r == ST_MARCH) && (issue_k_r < max_steps_r);
  assign step_ctl.load = in_acc;
  assign step_ctl.adv  = issue;

  vrme_axis u_axis_x (
    .clk        (clk),
    .ctl        (step_ctl),
    .origin     (in_tdata[40:25]),
    .dir        (dx_r),
    .world_cell (wx)
  );

  vrme_axis u_axis_y (
    .clk        (clk),
    .ctl        (step_ctl),
    .origin     (in_tdata[56:41]),
    .dir        (dy_r),
    .world_cell (wy)
  );

  vrme_axis u_axis_z (
    .clk        (clk),
    .ctl        (step_ctl),
    .origin     (in_tdata[72:57]),
    .dir        (dz_r),
    .world_cell (wz)
  );

  // store addresses
  always_comb begin
    cell_ref  = vrme_pkg::cell_addr(W_W'(cx_r), W_W'(cy_r), W_W'(cz_r),
                                    go_x_r, go_y_r, go_z_r);
    march_ref = vrme_pkg::cell_addr(wx, wy, wz, go_x_r, go_y_r, go_z_r);
    hit_ref   = vrme_pkg::cell_addr(pw_x_r, pw_y_r, pw_z_r, go_x_r, go_y_r, go_z_r);
  end

  // face normal from the dominant direction axis, +z on the first sample
  always_comb begin
    ax = dx_r[15] ? 17'(~dx_r) + 17'd1 : 17'(dx_r);
    ay = dy_r[15] ? 17'(~dy_r) + 17'd1 : 17'(dy_r);
    az = dz_r[15] ? 17'(~dz_r) + 17'd1 : 17'(dz_r);
    priority if (pipe_first_r) begin
      n_axis = vrme_pkg::AXIS_Z;
      n_neg  = 1'b0;
    end else if (ax > ay && ax > az) begin
      n_axis = vrme_pkg::AXIS_X;
      n_neg  = !dx_r[15] && (dx_r != '0);
    end else if (ay > az) begin
      n_axis = vrme_pkg::AXIS_Y;
      n_neg  = !dy_r[15] && (dy_r != '0);
    end else begin
      n_axis = vrme_pkg::AXIS_Z;
      n_neg  = !dz_r[15] && (dz_r != '0);
    end
  end

  // place target: hit cell moved one cell along the normal
  always_comb begin
    off = n_neg ? -W_W'(1) : W_W'(1);
    tx  = pw_x_r + ((n_axis == vrme_pkg::AXIS_X) ? off : W_W'(0));
    ty  = pw_y_r + ((n_axis == vrme_pkg::AXIS_Y) ? off : W_W'(0));
    tz  = pw_z_r + ((n_axis == vrme_pkg::AXIS_Z) ? off : W_W'(0));
    place_ref = vrme_pkg::cell_addr(tx, ty, tz, go_x_r, go_y_r, go_z_r);
  end

  assign hit_now = pipe_valid_r && pipe_ok_r && ram_rdata[0];

  // store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_ref.addr;
    ram_wdata = cval_r;
    ram_raddr = (state_r == ST_MARCH) ? march_ref.addr : cell_ref.addr;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = 1'b0;
      end
      ST_CELL: begin
        ram_we = (kind_r == vrme_pkg::KIND_WRITE) && cell_ref.ok;
      end
      ST_EDIT: begin
        ram_we    = edit_ok_r;
        ram_waddr = edit_addr_r;
        ram_wdata = edit_val_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  vrme_ram #(
    .WIDTH (1),
    .DEPTH (vrme_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, march pipeline and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      pipe_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // result taken; the finishing state reloads the register itself
      if (out_valid_r && out_tready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(vrme_pkg::DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            kind_r       <= in_tuser;
            cx_r         <= in_tdata[7:0];
            cy_r         <= in_tdata[15:8];
            cz_r         <= in_tdata[23:16];
            cval_r       <= in_tdata[24];
            dx_r         <= in_tdata[88:73];
            dy_r         <= in_tdata[104:89];
            dz_r         <= in_tdata[120:105];
            issue_k_r    <= '0;
            pipe_valid_r <= 1'b0;
            if (in_tuser == vrme_pkg::KIND_WRITE || in_tuser == vrme_pkg::KIND_QUERY) begin
              state_r <= ST_CELL;
            end else begin
              state_r <= ST_MARCH;
            end
          end
        end
        ST_CELL: begin
          res_r  <= '0;
          q_ok_r <= cell_ref.ok;
          state_r <= (kind_r == vrme_pkg::KIND_QUERY) ? ST_QRD : ST_DONE;
        end
        ST_QRD: begin
          res_r.solid <= q_ok_r && ram_rdata[0];
          state_r     <= ST_DONE;
        end
        ST_MARCH: begin
          pipe_valid_r <= issue && !hit_now;
          pipe_ok_r    <= march_ref.ok;
          pipe_first_r <= (issue_k_r == '0);
          pw_x_r       <= wx;
          pw_y_r       <= wy;
          pw_z_r       <= wz;
          if (issue) begin
            issue_k_r <= issue_k_r + 8'd1;
          end
          if (hit_now) begin
            res_r <= '{solid: 1'b0, normal_negative: n_neg, normal_axis: n_axis,
                       hit_z: pw_z_r[7:0], hit_y: pw_y_r[7:0], hit_x: pw_x_r[7:0],
                       hit: 1'b1};
            if (kind_r == vrme_pkg::KIND_PLACE) begin
              edit_ok_r   <= place_ref.ok;
              edit_addr_r <= place_ref.addr;
              edit_val_r  <= 1'b1;
            end else begin
              edit_ok_r   <= hit_ref.ok;
              edit_addr_r <= hit_ref.addr;
              edit_val_r  <= 1'b0;
            end
            state_r <= ST_EDIT;
          end else if (!issue && !pipe_valid_r) begin
            res_r   <= '0;
            state_r <= ST_DONE;
          end
        end
        ST_EDIT: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // the march only reads the store
  a_no_write_in_march: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARCH) |-> !ram_we)
    else $error("store written during march");

  // a pending read check comes only from a march issue
  a_pipe_from_march: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_valid_r |-> $past(state_r == ST_MARCH))
    else $error("march read check outside march");

  // a new result appears only from the finishing state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside finish");

endmodule

>>> bench/tb_voxel_ray_march_edit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_ray_march_edit: self-checking bench for the voxel ray march editor
// Drives write, query, break and place items over the input stream. Every
// accepted item is run through a scoreboard that keeps its own voxel store
// and grid settings and predicts the result item. Results are compared field
// by field, in order. A directed opening covers edge cases. Random phases
// follow under several grid origins and step limits. Both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_voxel_ray_march_edit;

  // a sample point is kept in units of 1/(20*2^14) of a cell
  localparam longint SUBCELL       = 327680;
  localparam longint ORIGIN_TO_SUB = 1280;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 238;

  // item fields from the highest bit down, as on in_tdata
  typedef struct packed {
    logic signed [15:0] dz;
    logic signed [15:0] dy;
    logic signed [15:0] dx;
    logic signed [15:0] oz;
    logic signed [15:0] oy;
    logic signed [15:0] ox;
    logic               cv;
    logic signed [7:0]  cz;
    logic signed [7:0]  cy;
    logic signed [7:0]  cx;
  } ray_item_t;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_PULSE, RX_CHOKE} rx_mode_t;

  // voxel store shadow, grid settings and the queue of awaited results
  class voxel_scoreboard;
    bit                occupied [vrme_pkg::DEPTH];
    int                org_x;
    int                org_y;
    int                org_z;
    int                step_limit;
    vrme_pkg::result_t awaited [$];
    int                errors;

    function new();
      org_x      = 0;
      org_y      = 0;
      org_z      = 0;
      step_limit = 120;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        vrme_pkg::CFG_ORIGIN_X:  org_x = $signed(val);
        vrme_pkg::CFG_ORIGIN_Y:  org_y = $signed(val);
        vrme_pkg::CFG_ORIGIN_Z:  org_z = $signed(val);
        vrme_pkg::CFG_MAX_STEPS: step_limit = val;
        default: ;
      endcase
    endfunction

    // store slot of a world cell, -1 outside the grid
    function int cell_slot(longint wx, longint wy, longint wz);
      longint lx;
      longint ly;
      longint lz;
      lx = wx - org_x;
      ly = wy - org_y;
      lz = wz - org_z;
      if (lx < 0 || ly < 0 || lz < 0 || lx >= vrme_pkg::GRID_SIZE ||
          ly >= vrme_pkg::GRID_SIZE || lz >= vrme_pkg::GRID_SIZE) begin
        return -1;
      end
      return int'((lx * vrme_pkg::GRID_SIZE + ly) * vrme_pkg::GRID_SIZE + lz);
    endfunction

    function bit solid_at(longint wx, longint wy, longint wz);
      int slot;
      slot = cell_slot(wx, wy, wz);
      return slot >= 0 && occupied[slot];
    endfunction

    function void store_cell(longint wx, longint wy, longint wz, bit v);
      int slot;
      slot = cell_slot(wx, wy, wz);
      if (slot >= 0) begin
        occupied[slot] = v;
      end
    endfunction

    function longint floor_cell(longint p);
      longint q;
      q = p / SUBCELL;
      if (p % SUBCELL != 0 && p < 0) begin
        q -= 1;
      end
      return q;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // predict the result of one accepted item and update the shadow store
    function void note_item(logic [1:0] kind, ray_item_t it);
      vrme_pkg::result_t r;
      longint            ox, oy, oz, dx, dy, dz;
      longint            wx, wy, wz, s;
      int                k;
      r = '0;
      case (kind)
        vrme_pkg::KIND_WRITE:
          store_cell($signed(it.cx), $signed(it.cy), $signed(it.cz), it.cv);
        vrme_pkg::KIND_QUERY:
          r.solid = solid_at($signed(it.cx), $signed(it.cy), $signed(it.cz));
        default: begin
          ox = $signed(it.ox);
          oy = $signed(it.oy);
          oz = $signed(it.oz);
          dx = $signed(it.dx);
          dy = $signed(it.dy);
          dz = $signed(it.dz);
          for (k = 0; k < step_limit; k++) begin
            wx = floor_cell(ox * ORIGIN_TO_SUB + dx * k);
            wy = floor_cell(oy * ORIGIN_TO_SUB + dy * k);
            wz = floor_cell(oz * ORIGIN_TO_SUB + dz * k);
            if (solid_at(wx, wy, wz)) begin
              r.hit   = 1'b1;
              r.hit_x = wx[7:0];
              r.hit_y = wy[7:0];
              r.hit_z = wz[7:0];
              // step zero has no step difference: face is +z
              if (k == 0) begin
                r.normal_axis     = vrme_pkg::AXIS_Z;
                r.normal_negative = 1'b0;
              end else if (mag(dx) > mag(dy) && mag(dx) > mag(dz)) begin
                r.normal_axis     = vrme_pkg::AXIS_X;
                r.normal_negative = dx > 0;
              end else if (mag(dy) > mag(dz)) begin
                r.normal_axis     = vrme_pkg::AXIS_Y;
                r.normal_negative = dy > 0;
              end else begin
                r.normal_axis     = vrme_pkg::AXIS_Z;
                r.normal_negative = dz > 0;
              end
              if (kind == vrme_pkg::KIND_BREAK) begin
                store_cell(wx, wy, wz, 1'b0);
              end else begin
                s = r.normal_negative ? -1 : 1;
                store_cell(wx + (r.normal_axis == vrme_pkg::AXIS_X ? s : 0),
                           wy + (r.normal_axis == vrme_pkg::AXIS_Y ? s : 0),
                           wz + (r.normal_axis == vrme_pkg::AXIS_Z ? s : 0), 1'b1);
              end
              break;
            end
          end
        end
      endcase
      awaited = {awaited, r};
    endfunction

    function void match(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(vrme_pkg::result_t got);
      vrme_pkg::result_t want;
      if (awaited.size() == 0) begin
        $error("result item with none awaited: %h", got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      match("hit", want.hit, got.hit);
      match("hit_x", want.hit_x, got.hit_x);
      match("hit_y", want.hit_y, got.hit_y);
      match("hit_z", want.hit_z, got.hit_z);
      match("normal_axis", want.normal_axis, got.normal_axis);
      match("normal_negative", want.normal_negative, got.normal_negative);
      match("solid", want.solid, got.solid);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic [vrme_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                      in_tuser;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [vrme_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [1:0]                      cfg_index;
  logic [7:0]                      cfg_data;

  voxel_scoreboard sb;
  int              sent       = 0;
  int              burst_left = 1;
  rx_mode_t        rx_mode    = RX_STREAM;
  logic [15:0]     rx_cycle   = '0;

  voxel_ray_march_edit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // receiver stall pattern, reselected each time the low nine bits of rx_cycle wrap to zero
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rx_cycle[8:0] == 9'd0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_STREAM: out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_PULSE:  out_tready <= rx_cycle[2:0] < 3'd2;
      default:   out_tready <= rx_cycle[5:0] == 6'd0;
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(vrme_pkg::result_t'(out_tdata[28:0]));
    end
  end

  // full random item, every field bit free
  function automatic ray_item_t scrambled();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[120:0];
  endfunction

  function automatic int clamp_q88(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  // world cell a little around the grid
  function automatic int cell_near(int g);
    return g + $urandom_range(0, 19) - 2;
  endfunction

  // ray start in Q8.8 a little around the grid
  function automatic int origin_near(int g);
    return clamp_q88(cell_near(g) * 256 + $urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] ray_kind();
    return $urandom_range(0, 1) ? vrme_pkg::KIND_BREAK : vrme_pkg::KIND_PLACE;
  endfunction

  // offer one item in bursts with random gaps between them
  task automatic send_item(input logic [1:0] kind, input ray_item_t it);
    int gap;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, it};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, it);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
      case ($urandom_range(0, 19))
        0:       gap = $urandom_range(100, 300);
        1, 2, 3: gap = $urandom_range(5, 40);
        default: gap = $urandom_range(1, 4);
      endcase
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_voxel(input int x, input int y, input int z, input bit v);
    ray_item_t it;
    it    = scrambled();
    it.cx = x[7:0];
    it.cy = y[7:0];
    it.cz = z[7:0];
    it.cv = v;
    send_item(vrme_pkg::KIND_WRITE, it);
  endtask

  task automatic ask_voxel(input int x, input int y, input int z);
    ray_item_t it;
    it    = scrambled();
    it.cx = x[7:0];
    it.cy = y[7:0];
    it.cz = z[7:0];
    send_item(vrme_pkg::KIND_QUERY, it);
  endtask

  task automatic cast_ray(input logic [1:0] kind, input int ox, input int oy, input int oz,
                          input int dx, input int dy, input int dz);
    ray_item_t it;
    it    = scrambled();
    it.ox = ox[15:0];
    it.oy = oy[15:0];
    it.oz = oz[15:0];
    it.dx = dx[15:0];
    it.dy = dy[15:0];
    it.dz = dz[15:0];
    send_item(kind, it);
  endtask

  // unit direction from a real vector, +z when degenerate
  task automatic cast_along(input logic [1:0] kind, input int ox, input int oy, input int oz,
                            input real vx, input real vy, input real vz);
    real n;
    n = $sqrt(vx * vx + vy * vy + vz * vz);
    if (n < 0.01) begin
      cast_ray(kind, ox, oy, oz, 0, 0, 16384);
    end else begin
      cast_ray(kind, ox, oy, oz, $rtoi(vx / n * 16384.0), $rtoi(vy / n * 16384.0),
               $rtoi(vz / n * 16384.0));
    end
  endtask

  // make a cell solid, then aim a ray at it from a few cells away
  task automatic aimed_pair();
    logic signed [7:0] tx, ty, tz;
    int                ox, oy, oz;
    tx = sb.org_x + $urandom_range(0, 15);
    ty = sb.org_y + $urandom_range(0, 15);
    tz = sb.org_z + $urandom_range(0, 15);
    put_voxel(tx, ty, tz, 1'b1);
    ox = clamp_q88(tx * 256 + 128 + int'($urandom_range(0, 2048)) - 1024);
    oy = clamp_q88(ty * 256 + 128 + int'($urandom_range(0, 2048)) - 1024);
    oz = clamp_q88(tz * 256 + 128 + int'($urandom_range(0, 2048)) - 1024);
    cast_along(ray_kind(), ox, oy, oz, tx + 0.5 - ox / 256.0, ty + 0.5 - oy / 256.0,
               tz + 0.5 - oz / 256.0);
  endtask

  task automatic random_ray();
    int vx, vy, vz;
    vx = $urandom_range(0, 32768) - 16384;
    vy = $urandom_range(0, 32768) - 16384;
    vz = $urandom_range(0, 32768) - 16384;
    if ($urandom_range(0, 9) < 6) begin
      cast_along(ray_kind(), origin_near(sb.org_x), origin_near(sb.org_y),
                 origin_near(sb.org_z), vx, vy, vz);
    end else begin
      cast_ray(ray_kind(), origin_near(sb.org_x), origin_near(sb.org_y),
               origin_near(sb.org_z), vx, vy, vz);
    end
  endtask

  // wait until every awaited result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic reconfigure(input int gx, input int gy, input int gz, input int steps);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    settle();
    idx = '{vrme_pkg::CFG_ORIGIN_X, vrme_pkg::CFG_ORIGIN_Y, vrme_pkg::CFG_ORIGIN_Z,
            vrme_pkg::CFG_MAX_STEPS};
    val = '{gx[7:0], gy[7:0], gz[7:0], steps[7:0]};
    for (int r = 0; r < 4; r++) begin
      cfg_index <= idx[r];
      cfg_data  <= val[r];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[r], val[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  // run limit
  initial begin
    #40_000_000;
    $display("tb_voxel_ray_march_edit: FAIL");
    $finish;
  end

  initial begin
    int target;
    int pick;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= vrme_pkg::KIND_WRITE;
    cfg_valid <= 1'b0;
    cfg_index <= vrme_pkg::CFG_ORIGIN_X;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // the store is swept clear before the first item is taken
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // directed: basic write and query, step-zero break
    reconfigure(0, 0, 0, 120);
    ask_voxel(0, 0, 0);
    put_voxel(0, 0, 0, 1'b1);
    ask_voxel(0, 0, 0);
    cast_ray(vrme_pkg::KIND_BREAK, 128, 128, 128, 16384, 0, 0);
    ask_voxel(0, 0, 0);
    // x-dominant place puts a block on the -x face
    put_voxel(5, 2, 2, 1'b1);
    cast_ray(vrme_pkg::KIND_PLACE, 128, 2 * 256 + 128, 2 * 256 + 128, 16384, 0, 0);
    ask_voxel(4, 2, 2);
    // x equal to y: y wins; all three equal: z wins
    put_voxel(8, 8, 3, 1'b1);
    cast_ray(vrme_pkg::KIND_BREAK, 5 * 256 + 128, 5 * 256 + 128, 3 * 256 + 128,
             11585, 11585, 0);
    put_voxel(10, 10, 10, 1'b1);
    cast_ray(vrme_pkg::KIND_PLACE, 7 * 256 + 128, 7 * 256 + 128, 7 * 256 + 128,
             9459, 9459, 9459);
    // cells outside the grid and field extremes
    put_voxel(-1, 0, 0, 1'b1);
    ask_voxel(-1, 0, 0);
    put_voxel(127, -128, 127, 1'b1);
    ask_voxel(-128, 127, -128);
    // place target past the grid edge is dropped
    put_voxel(15, 15, 15, 1'b1);
    cast_ray(vrme_pkg::KIND_PLACE, 15 * 256 + 128, 15 * 256 + 128, 20 * 256 + 128,
             0, 0, -16384);
    // direction beyond unit length, origin extremes
    cast_ray(vrme_pkg::KIND_BREAK, 32767, -32768, 32767, 32767, -32768, 0);
    cast_ray(vrme_pkg::KIND_PLACE, -32768, 32767, -32768, -16384, 16384, -16384);
    // zero steps never hit, one step hits on step zero
    reconfigure(0, 0, 0, 0);
    put_voxel(0, 0, 0, 1'b1);
    cast_ray(vrme_pkg::KIND_BREAK, 128, 128, 128, 16384, 0, 0);
    reconfigure(0, 0, 0, 1);
    cast_ray(vrme_pkg::KIND_BREAK, 128, 128, 128, 16384, 0, 0);
    // hit beyond world cell 127 wraps in the result
    reconfigure(127, 127, 127, 255);
    put_voxel(127, 127, 127, 1'b1);
    cast_ray(vrme_pkg::KIND_PLACE, 32640, 32640, 32640, -16384, 0, 0);
    put_voxel(127, 127, 127, 1'b0);
    cast_ray(vrme_pkg::KIND_BREAK, 32640, 32640, 32640, 0, 0, 16384);

    // random phases under several grid settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: reconfigure(0, 0, 0, 120);
        1: reconfigure(-128, -128, -128, 255);
        2: reconfigure(127, 127, 127, 255);
        3: reconfigure($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), 0);
        4: reconfigure($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), 1);
        5: reconfigure($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
        6: reconfigure(-8, 100, -50, 200);
        default: reconfigure($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), 120);
      endcase
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          aimed_pair();
        end else if (pick < 55) begin
          put_voxel(cell_near(sb.org_x), cell_near(sb.org_y), cell_near(sb.org_z),
                    $urandom_range(0, 3) != 0);
        end else if (pick < 65) begin
          ask_voxel(cell_near(sb.org_x), cell_near(sb.org_y), cell_near(sb.org_z));
        end else if (pick < 92) begin
          random_ray();
        end else begin
          send_item(2'($urandom), scrambled());
        end
      end
    end

    settle();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_voxel_ray_march_edit: PASS");
    end else begin
      $display("tb_voxel_ray_march_edit: FAIL");
    end
    $finish;
  end

endmodule
